// ===== rtl/swo_pkg.sv =====
// ----------------------------------------------------------------------------
// swo_pkg
// Types, constants and the sine table builder for the swept oscillator.
// ----------------------------------------------------------------------------
package swo_pkg;

    localparam int          STEP_BITS   = 48;
    localparam int          MAG_BITS    = 15;
    localparam int          SAMPLE_BITS = 16;
    localparam int          CFG_BITS    = 32;
    localparam logic [14:0] AMP         = 15'd32760;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [31:0] RATIO_ONE   = 32'h4000_0000;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_SQUARE = 2'd2,
        WAVE_SILENT = 2'd3
    } t_wave_mode;

    typedef enum logic [1:0] {
        CFG_WAVE_MODE   = 2'd0,
        CFG_START_STEP  = 2'd1,
        CFG_SWEEP_EN    = 2'd2,
        CFG_SWEEP_RATIO = 2'd3
    } t_cfg_reg;

    // Quarter-wave entry k, Taylor series on x in 2.30, scaled by AMP.
    function automatic logic [14:0] sine_entry(input int k, input int addr_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x    = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        v = ($unsigned(sum) * 64'(AMP)) >> 30;
        if (v > 64'(AMP)) begin
            v = 64'(AMP);
        end
        return v[14:0];
    endfunction

endpackage

// ===== rtl/swept_waveform_oscillator_unit.sv =====
// ----------------------------------------------------------------------------
// swept_waveform_oscillator_unit
// DDS oscillator with quarter-wave sine, sawtooth and square outputs and an
// exponential step sweep.
// ----------------------------------------------------------------------------
// Takes one item per clock while o_stall is low and gives one sample per item.
// The phase register feeds the sample logic, and the sample is registered in the
// output register when the output is not stalled. The step loop holds the phase
// add and the 48x32 sweep multiply (two 24x32 partial products), which close on
// the phase and step registers. The sine table is a constant quarter-wave table of
// 2^SINE_ADDR_BITS entries. start_step takes effect at the next item with restart
// set; the other registers act at once.
module swept_waveform_oscillator_unit #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic                                    i_restart,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [swo_pkg::SAMPLE_BITS-1:0]  o_sample,
    input  logic                                    i_cfg_we,
    input  logic [1:0]                              i_cfg_index,
    input  logic [swo_pkg::CFG_BITS-1:0]            i_cfg_data
);

    localparam int TABLE_LEN = 1 << SINE_ADDR_BITS;
    localparam int SAW_W     = PHASE_BITS + 1;
    localparam int PROD_W    = SAW_W + swo_pkg::MAG_BITS;
    localparam int SB        = swo_pkg::STEP_BITS;

    // configuration
    swo_pkg::t_wave_mode r_mode;
    logic [31:0]         r_start_step;
    logic                r_sweep_en;
    logic [31:0]         r_ratio;

    // state and pipeline
    logic [PHASE_BITS-1:0] r_phase;
    logic [SB-1:0]         r_step;
    logic                  r_s1_valid;
    logic signed [15:0]    r_sample;
    logic                  r_out_valid;

    logic [PHASE_BITS-1:0] n_phase;
    logic [SB-1:0]         n_step;
    logic signed [15:0]    n_sample;

    logic w_accept;
    logic w_out_ready;
    logic w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= swo_pkg::WAVE_SINE;
            r_start_step <= '0;
            r_sweep_en   <= 1'b0;
            r_ratio      <= swo_pkg::RATIO_ONE;
        end else if (i_cfg_we) begin
            unique case (swo_pkg::t_cfg_reg'(i_cfg_index))
                swo_pkg::CFG_WAVE_MODE:   r_mode       <= swo_pkg::t_wave_mode'(i_cfg_data[1:0]);
                swo_pkg::CFG_START_STEP:  r_start_step <= i_cfg_data[31:0];
                swo_pkg::CFG_SWEEP_EN:    r_sweep_en   <= i_cfg_data[0];
                swo_pkg::CFG_SWEEP_RATIO: r_ratio      <= i_cfg_data[31:0];
                default:                  r_mode       <= r_mode;
            endcase
        end
    end

    // handshake
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_s1_ready  = !r_s1_valid || w_out_ready;
    assign o_stall     = !w_s1_ready;
    assign w_accept    = i_valid && w_s1_ready;

    // step loop
    logic [SB-1:0]         w_step_eff;
    logic [PHASE_BITS-1:0] w_phase_base;
    logic [55:0]           w_p_lo;
    logic [55:0]           w_p_hi;
    logic [56:0]           w_low_sum;
    logic [50:0]           w_sweep_sum;
    logic [SB-1:0]         w_step_swept;

    assign w_step_eff   = i_restart ? {r_start_step, 16'b0} : r_step;
    assign w_phase_base = i_restart ? '0 : r_phase;
    assign n_phase      = w_phase_base + w_step_eff[SB-1 -: PHASE_BITS];

    assign w_p_lo      = 56'(w_step_eff[23:0]) * 56'(r_ratio);
    assign w_p_hi      = 56'(w_step_eff[47:24]) * 56'(r_ratio);
    assign w_low_sum   = 57'({w_p_hi[5:0], 24'b0}) + 57'(w_p_lo);
    assign w_sweep_sum = 51'(w_p_hi[55:6]) + 51'(w_low_sum[56:30]);
    assign w_step_swept = (|w_sweep_sum[50:48]) ? '1 : w_sweep_sum[47:0];
    assign n_step       = r_sweep_en ? w_step_swept : w_step_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_step     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_step  <= n_step;
            end
            if (w_s1_ready) begin
                r_s1_valid <= i_valid;
            end
        end
    end

    // sine table
    logic [14:0] w_sine_rom [TABLE_LEN];

    for (genvar k = 0; k < TABLE_LEN; k++) begin : g_rom
        assign w_sine_rom[k] = swo_pkg::sine_entry(k, SINE_ADDR_BITS);
    end

    // sample from phase
    logic [1:0]                w_quad;
    logic [SINE_ADDR_BITS-1:0] w_addr;
    logic [SINE_ADDR_BITS-1:0] w_addr_rd;
    logic [14:0]               w_sin_mag;
    logic signed [15:0]        w_sin;
    logic [SAW_W-1:0]          w_saw_d;
    logic [PROD_W-1:0]         w_saw_prod;
    logic [14:0]               w_saw_mag;
    logic signed [15:0]        w_saw;
    logic signed [15:0]        w_sq;

    assign w_quad    = r_phase[PHASE_BITS-1 -: 2];
    assign w_addr    = r_phase[PHASE_BITS-3 -: SINE_ADDR_BITS];
    assign w_addr_rd = w_quad[0] ? (~w_addr + 1'b1) : w_addr;
    assign w_sin_mag = (w_quad[0] && (w_addr == '0)) ? swo_pkg::AMP : w_sine_rom[w_addr_rd];
    assign w_sin     = w_quad[1] ? -$signed({1'b0, w_sin_mag}) : $signed({1'b0, w_sin_mag});

    assign w_saw_d    = r_phase[PHASE_BITS-1]
                      ? {1'b0, r_phase[PHASE_BITS-2:0], 1'b0}
                      : ({1'b1, {PHASE_BITS{1'b0}}} - {1'b0, r_phase[PHASE_BITS-2:0], 1'b0});
    assign w_saw_prod = PROD_W'(w_saw_d) * PROD_W'(swo_pkg::AMP);
    assign w_saw_mag  = w_saw_prod[PHASE_BITS +: 15];
    assign w_saw      = r_phase[PHASE_BITS-1] ? $signed({1'b0, w_saw_mag})
                                              : -$signed({1'b0, w_saw_mag});

    assign w_sq = r_phase[PHASE_BITS-1] ? -$signed({1'b0, swo_pkg::AMP})
                                        : $signed({1'b0, swo_pkg::AMP});

    always_comb begin
        unique case (r_mode)
            swo_pkg::WAVE_SINE:   n_sample = w_sin;
            swo_pkg::WAVE_SAW:    n_sample = w_saw;
            swo_pkg::WAVE_SQUARE: n_sample = w_sq;
            swo_pkg::WAVE_SILENT: n_sample = '0;
            default:              n_sample = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_s1_valid) begin
            r_sample <= n_sample;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

`ifndef SYNTH
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with room in the pipeline");

    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_step) && $stable(r_phase))
        else $error("oscillator state moved without an item");

    a_restart_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_restart && !r_sweep_en) |=> (r_step == {$past(r_start_step), 16'b0}))
        else $error("restart did not load the start step");

    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample <= 16'sd32760) && (o_sample >= -16'sd32760))
        else $error("sample out of range");
`endif

endmodule

// ===== tb/sv/tb_swept_waveform_oscillator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_swept_waveform_oscillator_unit
// Self-checking bench for the swept DDS oscillator. A queue-fed driver offers
// sample ticks and an in-bench model of the phase, step and waveform logic
// predicts each sample. A monitor with random back-pressure compares every
// returned sample in order. Directed ticks cover the reset state, every mode,
// quadrant peaks, register masking, step saturation and stopped phase. Random
// phases follow with varied register settings and handshake gaps.
// ----------------------------------------------------------------------------
module tb_swept_waveform_oscillator_unit;

    localparam int TBL_ADDR_BITS  = 8;
    localparam int TBL_LEN        = 1 << TBL_ADDR_BITS;
    localparam int PEAK           = int'(swo_pkg::AMP);
    localparam int SETTLE_CYCLES  = 8;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int PHASES_PER_RUN = 4;
    localparam int TICKS_PER_PH   = 34;

    logic                                   i_clk       = 1'b0;
    logic                                   i_rst_n     = 1'b0;
    logic                                   i_valid     = 1'b0;
    logic                                   o_stall;
    logic                                   i_restart   = 1'b0;
    logic                                   o_valid;
    logic                                   i_stall     = 1'b0;
    logic signed [swo_pkg::SAMPLE_BITS-1:0] o_sample;
    logic                                   i_cfg_we    = 1'b0;
    logic [1:0]                             i_cfg_index = 2'd0;
    logic [swo_pkg::CFG_BITS-1:0]           i_cfg_data  = '0;

    swept_waveform_oscillator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sample    (o_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Register shadow and oscillator state of the model
    swo_pkg::t_wave_mode           cfg_mode  = swo_pkg::WAVE_SINE;
    logic [31:0]                   cfg_start = '0;
    logic                          cfg_sweep = 1'b0;
    logic [31:0]                   cfg_ratio = swo_pkg::RATIO_ONE;
    logic [31:0]                   osc_phase = '0;
    logic [swo_pkg::STEP_BITS-1:0] osc_step  = '0;
    logic [14:0]                   sine_rom [TBL_LEN];

    logic                                   tick_q [$];
    logic signed [swo_pkg::SAMPLE_BITS-1:0] sample_exp_q [$];
    logic signed [swo_pkg::SAMPLE_BITS-1:0] want;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int rx_hold_cycles = 0;
    int err_cnt        = 0;
    int cycle_cnt      = 0;

    always #5 i_clk = ~i_clk;

    function automatic logic [14:0] quarter_sine(input int k);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned mag;
        longint          acc;
        int              n;
        ang    = (swo_pkg::HALF_PI_Q30 * 64'(k)) >> TBL_ADDR_BITS;
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (n = 1; n <= 8; n++) begin
            term = ((term * ang_sq) >> 30) / $unsigned(64'(2 * n * (2 * n + 1)));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        mag = ($unsigned(acc) * $unsigned(64'(PEAK))) >> 30;
        if (mag > $unsigned(64'(PEAK))) begin
            mag = $unsigned(64'(PEAK));
        end
        return 15'(mag);
    endfunction

    // One tick: optional restart, phase advance, sample, then sweep
    task automatic advance_oscillator(input logic restart);
        logic [1:0]      quad;
        logic [7:0]      addr;
        logic [7:0]      mirror;
        logic [32:0]     twice;
        logic [79:0]     prod;
        logic [49:0]     scaled;
        longint unsigned span;
        int              mag;
        logic signed [swo_pkg::SAMPLE_BITS-1:0] s;
        if (restart) begin
            osc_phase = '0;
            osc_step  = {cfg_start, 16'h0000};
        end
        osc_phase = osc_phase + osc_step[swo_pkg::STEP_BITS-1:swo_pkg::STEP_BITS-32];
        case (cfg_mode)
            swo_pkg::WAVE_SINE: begin
                quad   = osc_phase[31:30];
                addr   = osc_phase[29:22];
                mirror = 8'd0 - addr;
                if (quad[0]) begin
                    mag = (addr == 8'd0) ? PEAK : int'(sine_rom[mirror]);
                end else begin
                    mag = int'(sine_rom[addr]);
                end
                s = quad[1] ? 16'(-mag) : 16'(mag);
            end
            swo_pkg::WAVE_SAW: begin
                twice = {osc_phase, 1'b0};
                if (twice[32]) begin
                    span = 64'(twice) - 64'h1_0000_0000;
                    s    = 16'((span * 64'(PEAK)) >> 32);
                end else begin
                    span = 64'h1_0000_0000 - 64'(twice);
                    s    = 16'(-longint'((span * 64'(PEAK)) >> 32));
                end
            end
            swo_pkg::WAVE_SQUARE: begin
                s = osc_phase[31] ? 16'(-PEAK) : 16'(PEAK);
            end
            default: begin
                s = '0;
            end
        endcase
        sample_exp_q.push_back(s);
        if (cfg_sweep) begin
            prod   = 80'(osc_step) * 80'(cfg_ratio);
            scaled = prod[79:30];
            osc_step = (|scaled[49:48]) ? '1 : scaled[47:0];
        end
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                advance_oscillator(i_restart);
            end
            if (!i_valid || !o_stall) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid   <= 1'b1;
                    i_restart <= tick_q.pop_front();
                end else begin
                    i_valid   <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (sample_exp_q.size() == 0) begin
                    $display("%0t: unexpected sample, expected none, actual %0d",
                             $time, o_sample);
                    err_cnt++;
                end else begin
                    want = sample_exp_q.pop_front();
                    if (want !== o_sample) begin
                        $display("%0t: sample mismatch, expected %0d, actual %0d",
                                 $time, want, o_sample);
                        err_cnt++;
                    end
                end
            end
            if (rx_hold_cycles > 0) begin
                i_stall <= 1'b1;
                rx_hold_cycles--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input swo_pkg::t_cfg_reg idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            swo_pkg::CFG_WAVE_MODE:   cfg_mode  = swo_pkg::t_wave_mode'(data[1:0]);
            swo_pkg::CFG_START_STEP:  cfg_start = data;
            swo_pkg::CFG_SWEEP_EN:    cfg_sweep = data[0];
            swo_pkg::CFG_SWEEP_RATIO: cfg_ratio = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_run(input logic first_restart, input int count);
        int k;
        for (k = 0; k < count; k++) begin
            tick_q.push_back(k == 0 ? first_restart : 1'b0);
        end
    endtask

    task automatic wait_drained();
        while (tick_q.size() != 0 || i_valid || sample_exp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic pick_setup();
        logic [31:0] v;
        write_reg(swo_pkg::CFG_WAVE_MODE,
                  ($urandom() & 32'hFFFF_FFFC) | 32'($urandom_range(3)));
        case ($urandom_range(5))
            0, 1, 2: v = $urandom();
            3:       v = $urandom_range(32'h0010_0000);
            4:       v = 32'hFFFF_FFFF;
            default: v = 32'h0000_0000;
        endcase
        write_reg(swo_pkg::CFG_START_STEP, v);
        write_reg(swo_pkg::CFG_SWEEP_EN, $urandom());
        case ($urandom_range(5))
            0, 1, 2: v = swo_pkg::RATIO_ONE - 32'h0010_0000 + $urandom_range(32'h0020_0000);
            3:       v = $urandom();
            4:       v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
        endcase
        write_reg(swo_pkg::CFG_SWEEP_RATIO, v);
    endtask

    initial begin
        int stage;
        int ph;
        int k;
        for (k = 0; k < TBL_LEN; k++) begin
            sine_rom[k] = quarter_sine(k);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 46;

        // Reset state: zero step, phase held at zero in every mode
        push_run(1'b0, 2);
        wait_drained();
        write_reg(swo_pkg::CFG_WAVE_MODE, 32'hFFFF_FFFD);
        push_run(1'b0, 1);
        wait_drained();
        write_reg(swo_pkg::CFG_WAVE_MODE, 32'hFFFF_FFFE);
        push_run(1'b0, 1);
        wait_drained();
        write_reg(swo_pkg::CFG_WAVE_MODE, 32'h0000_0007);
        push_run(1'b0, 1);
        wait_drained();

        // Quarter-cycle step lands on quadrant boundaries
        write_reg(swo_pkg::CFG_WAVE_MODE, 32'(swo_pkg::WAVE_SINE));
        write_reg(swo_pkg::CFG_START_STEP, 32'h4000_0000);
        push_run(1'b1, 5);
        wait_drained();

        // Largest step
        write_reg(swo_pkg::CFG_WAVE_MODE, 32'(swo_pkg::WAVE_SAW));
        write_reg(swo_pkg::CFG_START_STEP, 32'hFFFF_FFFF);
        push_run(1'b1, 2);
        wait_drained();
        write_reg(swo_pkg::CFG_WAVE_MODE, 32'(swo_pkg::WAVE_SQUARE));
        push_run(1'b0, 1);
        wait_drained();

        // New start step is ignored until the next restart
        write_reg(swo_pkg::CFG_WAVE_MODE, 32'(swo_pkg::WAVE_SAW));
        write_reg(swo_pkg::CFG_START_STEP, 32'h8000_0000);
        push_run(1'b0, 2);
        push_run(1'b1, 1);
        wait_drained();

        // Sweep with largest ratio saturates the step
        write_reg(swo_pkg::CFG_WAVE_MODE, 32'(swo_pkg::WAVE_SINE));
        write_reg(swo_pkg::CFG_START_STEP, 32'h1000_0000);
        write_reg(swo_pkg::CFG_SWEEP_EN, 32'hFFFF_FFFF);
        write_reg(swo_pkg::CFG_SWEEP_RATIO, 32'hFFFF_FFFF);
        push_run(1'b1, 4);
        wait_drained();

        // Zero ratio, then zero start step: phase stops
        write_reg(swo_pkg::CFG_SWEEP_RATIO, 32'h0000_0000);
        push_run(1'b1, 2);
        wait_drained();
        write_reg(swo_pkg::CFG_START_STEP, 32'h0000_0000);
        write_reg(swo_pkg::CFG_SWEEP_RATIO, swo_pkg::RATIO_ONE);
        write_reg(swo_pkg::CFG_SWEEP_EN, 32'hFFFF_FFFE);
        push_run(1'b1, 2);
        wait_drained();

        for (stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 46;
                end
                1: begin
                    send_idle_pct = 46;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (ph = 0; ph < PHASES_PER_RUN; ph++) begin
                pick_setup();
                for (k = 0; k < TICKS_PER_PH; k++) begin
                    tick_q.push_back(k == 0 ? 1'($urandom_range(1))
                                            : ($urandom_range(9) == 0));
                end
                // long receiver hold while the driver keeps offering items
                if (stage == 2 && ph == 1) begin
                    rx_hold_cycles = 80;
                end
                wait_drained();
            end
        end

        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
